### hw/rtl/tdat_pkg.sv
// Shared types and constants for the time-of-day alarm table.
package tdat_pkg;

  localparam int S_TDATA_W  = 96;
  localparam int M_TDATA_W  = 72;
  localparam int MAX_FIRES  = 8;
  localparam int FIRE_CNT_W = $clog2(MAX_FIRES + 1);

  typedef logic [2:0] req_code_t;

  localparam req_code_t REQ_TICK   = 3'd0;
  localparam req_code_t REQ_ADD    = 3'd1;
  localparam req_code_t REQ_DELETE = 3'd2;
  localparam req_code_t REQ_UPDATE = 3'd3;
  localparam req_code_t REQ_CLEAR  = 3'd4;

  typedef struct packed {
    req_code_t   req_type;
    logic [31:0] entry_id;
    logic [5:0]  relay_pin;
    logic [4:0]  alarm_hour;
    logic [5:0]  alarm_minute;
    logic [31:0] duration_ms;
    logic [4:0]  now_hour;
    logic [5:0]  now_minute;
    logic        time_valid;
  } req_t;

  typedef struct packed {
    logic [31:0] id;
    logic [5:0]  pin;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [31:0] duration;
  } slot_t;

  typedef struct packed {
    logic accept;
    logic scan_start;
    logic advance;
    logic fire;
    logic set_hit;
    logic respond;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic is_tick;
    logic last;
    logic hit;
    logic fire_due;
    logic out_free;
  } dp_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SCAN,
    ST_RESP
  } state_t;

endpackage

### hw/rtl/tdat_ctrl.sv
// Controller state machine for the alarm table: sequences accept, slot scan and response.
module tdat_ctrl import tdat_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_PRIME;
        end
      end
      ST_PRIME: begin
        state_next = st.need_scan ? ST_SCAN : ST_RESP;
      end
      ST_SCAN: begin
        if (st.is_tick) begin
          if ((!st.fire_due || st.out_free) && st.last) begin
            state_next = ST_RESP;
          end
        end else if (st.hit || st.last) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (st.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_PRIME: begin
        cmd.scan_start = st.need_scan;
      end
      ST_SCAN: begin
        if (st.is_tick) begin
          // Hold on a due fire until the output register frees up.
          if (st.fire_due) begin
            cmd.fire    = st.out_free;
            cmd.advance = st.out_free;
          end else begin
            cmd.advance = 1'b1;
          end
        end else if (st.hit) begin
          cmd.set_hit = 1'b1;
        end else if (!st.last) begin
          cmd.advance = 1'b1;
        end
      end
      ST_RESP: begin
        cmd.respond = st.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### hw/rtl/tdat_dpath.sv
// Datapath for the alarm table: slot memory, flags, id counter and result register.
module tdat_dpath import tdat_pkg::*; #(
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  req_t        in_req,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  st,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        out_kind,
  output logic        out_success,
  output logic [31:0] out_id,
  output logic [5:0]  out_pin,
  output logic [31:0] out_dur,
  output logic        out_last
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  req_t                  req;
  logic [IDX_W-1:0]      idx;
  logic [FIRE_CNT_W-1:0] fires;
  logic                  hit;
  logic [NUM_SLOTS-1:0]  used;
  logic [NUM_SLOTS-1:0]  fired;
  logic [31:0]           id_counter;
  slot_t                 mem [NUM_SLOTS];
  slot_t                 rd_data;

  logic                  used_cur;
  logic                  fired_cur;
  logic                  minute_eq;
  logic                  is_add;
  logic                  is_idop;
  logic [31:0]           id_plus;
  logic [31:0]           next_id;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  mem_we;
  slot_t                 mem_wdata;
  logic                  resp_success;
  logic [31:0]           resp_id;

  assign used_cur  = used[idx];
  assign fired_cur = fired[idx];
  assign minute_eq = (rd_data.minute == req.now_minute);
  assign is_add    = (req.req_type == REQ_ADD);
  assign is_idop   = (req.req_type == REQ_DELETE) || (req.req_type == REQ_UPDATE);
  assign id_plus   = id_counter + 32'd1;
  assign next_id   = (id_plus == 32'd0) ? 32'd1 : id_plus;

  always_comb begin
    st.is_tick   = (req.req_type == REQ_TICK);
    st.need_scan = (st.is_tick && req.time_valid) || is_add ||
                   (is_idop && (req.entry_id != 32'd0));
    st.last      = (idx == LAST_IDX);
    st.hit       = is_add ? !used_cur : (used_cur && (rd_data.id == req.entry_id));
    st.fire_due  = used_cur && minute_eq && (rd_data.hour == req.now_hour) &&
                   !fired_cur && (fires < FIRE_CNT_W'(MAX_FIRES));
    st.out_free  = !out_valid || out_ready;
  end

  // Request capture and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req   <= in_req;
      fires <= '0;
      hit   <= 1'b0;
    end
    if (cmd.scan_start) begin
      idx <= '0;
    end else if (cmd.advance) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.fire) begin
      fires <= fires + FIRE_CNT_W'(1);
    end
    if (cmd.set_hit) begin
      hit <= 1'b1;
    end
  end

  // Slot memory, read one entry ahead of the scan index.
  assign rd_en   = cmd.scan_start || (cmd.advance && !st.last);
  assign rd_addr = cmd.scan_start ? '0 : idx + IDX_W'(1);
  assign mem_we  = cmd.respond && hit &&
                   (is_add || (req.req_type == REQ_UPDATE));

  always_comb begin
    mem_wdata.id       = is_add ? next_id : rd_data.id;
    mem_wdata.pin      = req.relay_pin;
    mem_wdata.hour     = req.alarm_hour;
    mem_wdata.minute   = req.alarm_minute;
    mem_wdata.duration = req.duration_ms;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    resp_success = 1'b0;
    resp_id      = 32'd0;
    case (req.req_type)
      REQ_TICK: begin
        resp_success = req.time_valid;
      end
      REQ_ADD: begin
        resp_success = hit;
        resp_id      = hit ? next_id : 32'd0;
      end
      REQ_DELETE, REQ_UPDATE: begin
        resp_success = hit;
        resp_id      = req.entry_id;
      end
      REQ_CLEAR: begin
        resp_success = 1'b1;
      end
      default: begin
        resp_success = 1'b0;
      end
    endcase
  end

  // Slot flags and id counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      fired      <= '0;
      id_counter <= 32'd0;
    end else begin
      if (cmd.advance && st.is_tick && used_cur && !minute_eq) begin
        fired[idx] <= 1'b0;
      end
      if (cmd.fire) begin
        fired[idx] <= 1'b1;
      end
      if (cmd.respond) begin
        case (req.req_type)
          REQ_ADD: begin
            if (hit) begin
              used[idx]  <= 1'b1;
              fired[idx] <= 1'b0;
              id_counter <= next_id;
            end
          end
          REQ_DELETE: begin
            if (hit) begin
              used[idx]  <= 1'b0;
              fired[idx] <= 1'b0;
            end
          end
          REQ_UPDATE: begin
            if (hit) begin
              fired[idx] <= 1'b0;
            end
          end
          REQ_CLEAR: begin
            used  <= '0;
            fired <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fire || cmd.respond) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      out_kind    <= 1'b1;
      out_success <= 1'b1;
      out_id      <= rd_data.id;
      out_pin     <= rd_data.pin;
      out_dur     <= rd_data.duration;
      out_last    <= 1'b0;
    end else if (cmd.respond) begin
      out_kind    <= 1'b0;
      out_success <= resp_success;
      out_id      <= resp_id;
      out_pin     <= 6'd0;
      out_dur     <= 32'd0;
      out_last    <= 1'b1;
    end
  end

endmodule

### hw/rtl/time_of_day_alarm_table.sv
// Top level of the time-of-day alarm table: stream ports, controller and datapath.
//
// The block keeps NUM_SLOTS alarm slots, each with an id, a relay pin, an hour,
// a minute, a duration and a fired mark. One request is handled at a time.
// A tick (with a known time) scans all slots, one per cycle, and returns a fire
// result for every used, unfired slot whose hour and minute match the current
// time (at most eight per tick), followed by a closing result with tlast set;
// a slot whose minute no longer matches gets its fired mark cleared so it fires
// again the next day. An add scans for the lowest free slot and returns a fresh
// nonzero id; delete and update scan for the lowest used slot with the given id
// (id 0 never matches); clear frees every slot but keeps the id counter.
// Each request gets exactly one result, except a tick, which also carries its
// fire results. A scan stops early on the first hit for add, delete and update;
// the scan is bound by the single read port of the slot memory, which delivers
// one slot per cycle. A stalled output stream holds the scan on a pending fire.
// The next request is taken as soon as the previous final result sits in the
// output register.
module time_of_day_alarm_table import tdat_pkg::*; #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // entry_id, relay_pin, alarm_hour, alarm_minute, duration_ms, now_hour,
  // now_minute, time_valid (lowest bit up), zero padded
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // req_type
  input  logic [2:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // success, result_id, fire_pin, fire_duration (lowest bit up), zero padded
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // result_kind
  output logic [0:0]           m_axis_tuser,
  output logic                 m_axis_tlast
);

  req_t        in_req;
  ctrl_cmd_t   cmd;
  dp_status_t  st;
  logic        out_kind;
  logic        out_success;
  logic [31:0] out_id;
  logic [5:0]  out_pin;
  logic [31:0] out_dur;

  // Unpack the incoming request.
  always_comb begin
    in_req.req_type     = s_axis_tuser;
    in_req.entry_id     = s_axis_tdata[31:0];
    in_req.relay_pin    = s_axis_tdata[37:32];
    in_req.alarm_hour   = s_axis_tdata[42:38];
    in_req.alarm_minute = s_axis_tdata[48:43];
    in_req.duration_ms  = s_axis_tdata[80:49];
    in_req.now_hour     = s_axis_tdata[85:81];
    in_req.now_minute   = s_axis_tdata[91:86];
    in_req.time_valid   = s_axis_tdata[92];
  end

  tdat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  tdat_dpath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .in_req      (in_req),
    .cmd         (cmd),
    .st          (st),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_kind    (out_kind),
    .out_success (out_success),
    .out_id      (out_id),
    .out_pin     (out_pin),
    .out_dur     (out_dur),
    .out_last    (m_axis_tlast)
  );

  // Pack the result; the top bit is padding.
  assign m_axis_tdata = {1'b0, out_dur, out_pin, out_id, out_success};
  assign m_axis_tuser = out_kind;

endmodule

### test/time_of_day_alarm_table_tb.sv
// Self-checking stream testbench for the time-of-day alarm table.
module time_of_day_alarm_table_tb import tdat_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS = 8;

  // Request codes the block does not know; it answers them with a plain failure.
  localparam req_code_t REQ_BAD_FIRST = 3'd5;
  localparam req_code_t REQ_BAD_LAST  = 3'd7;

  // Result kinds carried on m_axis_tuser.
  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_FIRE = 1'b1;

  localparam int RANDOM_REQS = 153;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic        kind;
    logic        success;
    logic [31:0] id;
    logic [5:0]  pin;
    logic [31:0] duration;
    logic        last;
  } alarm_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [2:0]           s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  // Requests waiting for the driver, and results still owed by the block.
  req_t          pending_reqs[$];
  alarm_result_t owed_results[$];
  req_t          req_on_bus = '0;

  int  reqs_queued   = 0;
  int  reqs_accepted = 0;
  int  error_count   = 0;
  // Set while both sides run without any idle cycle.
  bit  steady_flow   = 1'b0;

  // Shadow of the alarm table, advanced on every accepted request.
  logic        alarm_used     [NUM_SLOTS];
  logic [31:0] alarm_id       [NUM_SLOTS];
  logic [5:0]  alarm_pin      [NUM_SLOTS];
  logic [4:0]  alarm_hour     [NUM_SLOTS];
  logic [5:0]  alarm_minute   [NUM_SLOTS];
  logic [31:0] alarm_duration [NUM_SLOTS];
  logic        alarm_fired    [NUM_SLOTS];
  logic [31:0] issued_id;

  time_of_day_alarm_table #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #6 clk = ~clk;

  // Work out the results one accepted request causes and advance the shadow table.
  task automatic predict_alarm_results(input req_t r);
    int fires;
    int hit;
    fires = 0;
    hit = -1;
    case (r.req_type)
      REQ_TICK: begin
        if (r.time_valid) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (alarm_used[i]) begin
              // A slot whose minute has moved on is armed again for the next day.
              if (alarm_minute[i] != r.now_minute) begin
                alarm_fired[i] = 1'b0;
              end else if (alarm_hour[i] == r.now_hour && !alarm_fired[i] &&
                           fires < MAX_FIRES) begin
                owed_results.push_back('{KIND_FIRE, 1'b1, alarm_id[i], alarm_pin[i],
                                         alarm_duration[i], 1'b0});
                alarm_fired[i] = 1'b1;
                fires++;
              end
            end
          end
        end
        owed_results.push_back('{KIND_ACK, r.time_valid, 32'd0, 6'd0, 32'd0, 1'b1});
      end
      REQ_ADD: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (hit < 0 && !alarm_used[i]) hit = i;
        end
        if (hit >= 0) begin
          // Skip id 0 when the counter wraps.
          issued_id = (issued_id == 32'hFFFF_FFFF) ? 32'd1 : issued_id + 32'd1;
          alarm_used[hit]     = 1'b1;
          alarm_id[hit]       = issued_id;
          alarm_pin[hit]      = r.relay_pin;
          alarm_hour[hit]     = r.alarm_hour;
          alarm_minute[hit]   = r.alarm_minute;
          alarm_duration[hit] = r.duration_ms;
          alarm_fired[hit]    = 1'b0;
          owed_results.push_back('{KIND_ACK, 1'b1, issued_id, 6'd0, 32'd0, 1'b1});
        end else begin
          owed_results.push_back('{KIND_ACK, 1'b0, 32'd0, 6'd0, 32'd0, 1'b1});
        end
      end
      REQ_DELETE, REQ_UPDATE: begin
        if (r.entry_id != 32'd0) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (hit < 0 && alarm_used[i] && alarm_id[i] == r.entry_id) hit = i;
          end
        end
        if (hit >= 0) begin
          if (r.req_type == REQ_DELETE) begin
            alarm_used[hit] = 1'b0;
            alarm_id[hit]   = 32'd0;
          end else begin
            alarm_pin[hit]      = r.relay_pin;
            alarm_hour[hit]     = r.alarm_hour;
            alarm_minute[hit]   = r.alarm_minute;
            alarm_duration[hit] = r.duration_ms;
          end
          alarm_fired[hit] = 1'b0;
        end
        owed_results.push_back('{KIND_ACK, hit >= 0, r.entry_id, 6'd0, 32'd0, 1'b1});
      end
      REQ_CLEAR: begin
        // Free everything but keep the id counter running.
        for (int i = 0; i < NUM_SLOTS; i++) begin
          alarm_used[i]  = 1'b0;
          alarm_id[i]    = 32'd0;
          alarm_fired[i] = 1'b0;
        end
        owed_results.push_back('{KIND_ACK, 1'b1, 32'd0, 6'd0, 32'd0, 1'b1});
      end
      default: begin
        owed_results.push_back('{KIND_ACK, 1'b0, 32'd0, 6'd0, 32'd0, 1'b1});
      end
    endcase
  endtask

  // Driver: hold a request until the block takes it, then present the next one.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        predict_alarm_results(req_on_bus);
        reqs_accepted++;
      end
      if (pending_reqs.size() > 0 && (steady_flow || $urandom_range(99) >= 18)) begin
        req_on_bus = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req_on_bus.req_type;
        s_axis_tdata  <= {3'b000, req_on_bus.time_valid, req_on_bus.now_minute,
                          req_on_bus.now_hour, req_on_bus.duration_ms,
                          req_on_bus.alarm_minute, req_on_bus.alarm_hour,
                          req_on_bus.relay_pin, req_on_bus.entry_id};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Monitor: stall at random, compare every taken result with the oldest one owed.
  always @(posedge clk) begin
    alarm_result_t got;
    alarm_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tuser[0], m_axis_tdata[0], m_axis_tdata[32:1], m_axis_tdata[38:33],
                m_axis_tdata[70:39], m_axis_tlast};
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
          error_count++;
        end else begin
          want = owed_results.pop_front();
          check_field("result_kind", want.kind, got.kind);
          check_field("success", want.success, got.success);
          check_field("result_id", want.id, got.id);
          check_field("fire_pin", want.pin, got.pin);
          check_field("fire_duration", want.duration, got.duration);
          check_field("last_result", want.last, got.last);
        end
      end
      m_axis_tready <= steady_flow || ($urandom_range(99) >= 18);
    end
  end

  function automatic req_t make_req(req_code_t kind, logic [31:0] id, logic [5:0] pin,
                                    logic [4:0] hr, logic [5:0] mn, logic [31:0] dur,
                                    logic [4:0] now_h, logic [5:0] now_m, logic valid);
    req_t r;
    r.req_type     = kind;
    r.entry_id     = id;
    r.relay_pin    = pin;
    r.alarm_hour   = hr;
    r.alarm_minute = mn;
    r.duration_ms  = dur;
    r.now_hour     = now_h;
    r.now_minute   = now_m;
    r.time_valid   = valid;
    return r;
  endfunction

  task automatic queue_request(input req_t r);
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  // Pick a random occupied slot of the shadow table, or -1 if the table is empty.
  function automatic int pick_used_slot();
    int count;
    int k;
    count = 0;
    for (int i = 0; i < NUM_SLOTS; i++) count += alarm_used[i];
    if (count == 0) return -1;
    k = $urandom_range(count - 1);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (alarm_used[i]) begin
        if (k == 0) return i;
        k--;
      end
    end
    return -1;
  endfunction

  // Draw {hour, minute}; favor a few shared times so alarms collide and fire.
  function automatic logic [10:0] pick_alarm_time();
    logic [4:0] hot_hours[4]   = '{5'd0, 5'd7, 5'd16, 5'd23};
    logic [5:0] hot_minutes[4] = '{6'd0, 6'd31, 6'd32, 6'd59};
    if ($urandom_range(99) < 60) begin
      return {hot_hours[$urandom_range(3)], hot_minutes[$urandom_range(3)]};
    end
    return {5'($urandom_range(23)), 6'($urandom_range(59))};
  endfunction

  // Build one random request; fields the operation ignores stay random too.
  task automatic queue_random_request();
    req_t        r;
    int          roll;
    int          slot;
    logic [10:0] hm;
    r = make_req(REQ_TICK, $urandom, 6'($urandom_range(63)), 5'($urandom_range(23)),
                 6'($urandom_range(59)), $urandom, 5'($urandom_range(23)),
                 6'($urandom_range(59)), 1'b1);
    roll = $urandom_range(99);
    if (roll < 45) begin
      r.time_valid = ($urandom_range(99) >= 12);
      slot = pick_used_slot();
      if (slot >= 0 && $urandom_range(99) < 55) begin
        r.now_hour   = alarm_hour[slot];
        r.now_minute = alarm_minute[slot];
      end else begin
        hm = pick_alarm_time();
        {r.now_hour, r.now_minute} = hm;
      end
    end else if (roll < 93) begin
      r.req_type = (roll < 70) ? REQ_ADD : (roll < 81) ? REQ_DELETE : REQ_UPDATE;
      hm = pick_alarm_time();
      {r.alarm_hour, r.alarm_minute} = hm;
      roll = $urandom_range(99);
      slot = pick_used_slot();
      if (roll < 70 && slot >= 0) r.entry_id = alarm_id[slot];
      else if (roll < 80) r.entry_id = 32'd0;
      else if (roll < 90) r.entry_id = issued_id + 32'd1;
    end else if (roll < 96) begin
      r.req_type = REQ_CLEAR;
    end else begin
      r.req_type = req_code_t'($urandom_range(REQ_BAD_LAST, REQ_BAD_FIRST));
    end
    queue_request(r);
  endtask

  // Stall until the block has taken every request and returned every result.
  task automatic wait_for_drain();
    while (pending_reqs.size() != 0 || reqs_accepted != reqs_queued ||
           owed_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Bound the run even if the block hangs.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      alarm_used[i]     = 1'b0;
      alarm_id[i]       = 32'd0;
      alarm_pin[i]      = 6'd0;
      alarm_hour[i]     = 5'd0;
      alarm_minute[i]   = 6'd0;
      alarm_duration[i] = 32'd0;
      alarm_fired[i]    = 1'b0;
    end
    issued_id = 32'd0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty table, fill it, overflow, fire, re-arm, edit, clear.
    queue_request(make_req(REQ_TICK, 32'd0, 6'd0, 5'd0, 6'd0, 32'd0, 5'd0, 6'd0, 1'b0));
    queue_request(make_req(REQ_TICK, 32'd0, 6'd0, 5'd0, 6'd0, 32'd0, 5'd23, 6'd59, 1'b1));
    queue_request(make_req(REQ_DELETE, 32'd0, 6'd0, 5'd0, 6'd0, 32'd0, 5'd0, 6'd0, 1'b0));
    // Six alarms share 7:30; the last two sit at the extremes of the day.
    for (int i = 0; i < 6; i++) begin
      queue_request(make_req(REQ_ADD, 32'd0, (i == 0) ? 6'd0 : 6'd63 - 6'(i), 5'd7, 6'd30,
                             (i == 1) ? 32'hFFFF_FFFF : 32'(i * 250), 5'd0, 6'd0, 1'b0));
    end
    queue_request(make_req(REQ_ADD, 32'd0, 6'd63, 5'd0, 6'd0, 32'd0, 5'd0, 6'd0, 1'b0));
    queue_request(make_req(REQ_ADD, 32'd0, 6'd1, 5'd23, 6'd59, 32'hFFFF_FFFF,
                           5'd0, 6'd0, 1'b0));
    // Table full: the add must fail without consuming an id.
    queue_request(make_req(REQ_ADD, 32'd0, 6'd5, 5'd1, 6'd1, 32'd9, 5'd0, 6'd0, 1'b0));
    queue_request(make_req(REQ_TICK, 32'd0, 6'd0, 5'd0, 6'd0, 32'd0, 5'd7, 6'd30, 1'b1));
    // Same minute again: everything already fired.
    queue_request(make_req(REQ_TICK, 32'd0, 6'd0, 5'd0, 6'd0, 32'd0, 5'd7, 6'd30, 1'b1));
    // Minute moves on: re-arms the 7:30 alarms and fires the 23:59 one.
    queue_request(make_req(REQ_TICK, 32'd0, 6'd0, 5'd0, 6'd0, 32'd0, 5'd23, 6'd59, 1'b1));
    queue_request(make_req(REQ_TICK, 32'd0, 6'd0, 5'd0, 6'd0, 32'd0, 5'd7, 6'd30, 1'b1));
    queue_request(make_req(REQ_UPDATE, 32'd3, 6'd42, 5'd0, 6'd0, 32'd1234,
                           5'd0, 6'd0, 1'b0));
    queue_request(make_req(REQ_UPDATE, 32'd0, 6'd42, 5'd0, 6'd0, 32'd1234,
                           5'd0, 6'd0, 1'b0));
    queue_request(make_req(REQ_TICK, 32'd0, 6'd0, 5'd0, 6'd0, 32'd0, 5'd0, 6'd0, 1'b1));
    queue_request(make_req(REQ_DELETE, 32'd1, 6'd0, 5'd0, 6'd0, 32'd0, 5'd0, 6'd0, 1'b0));
    queue_request(make_req(REQ_DELETE, 32'd1, 6'd0, 5'd0, 6'd0, 32'd0, 5'd0, 6'd0, 1'b0));
    queue_request(make_req(REQ_ADD, 32'd0, 6'd33, 5'd16, 6'd32, 32'd77, 5'd0, 6'd0, 1'b0));
    queue_request(make_req(REQ_BAD_FIRST, 32'd2, 6'd1, 5'd1, 6'd1, 32'd1, 5'd1, 6'd1, 1'b1));
    queue_request(make_req(REQ_BAD_LAST, 32'd2, 6'd1, 5'd1, 6'd1, 32'd1, 5'd1, 6'd1, 1'b1));
    queue_request(make_req(REQ_CLEAR, 32'd0, 6'd0, 5'd0, 6'd0, 32'd0, 5'd0, 6'd0, 1'b0));
    queue_request(make_req(REQ_TICK, 32'd0, 6'd0, 5'd0, 6'd0, 32'd0, 5'd0, 6'd0, 1'b1));
    queue_request(make_req(REQ_DELETE, 32'hFFFF_FFFF, 6'd0, 5'd0, 6'd0, 32'd0,
                           5'd0, 6'd0, 1'b0));

    // Hold the sender off until the block has answered everything.
    wait_for_drain();

    // Random part: refill in small batches so ids track the shadow table.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      while (pending_reqs.size() >= 4) @(posedge clk);
      steady_flow = (n >= 60 && n < 110);
      queue_random_request();
    end

    wait_for_drain();
    steady_flow = 1'b0;
    // Let a stray result show up if the block makes one.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/tdat_pkg.sv
hw/rtl/tdat_ctrl.sv
hw/rtl/tdat_dpath.sv
hw/rtl/time_of_day_alarm_table.sv
test/time_of_day_alarm_table_tb.sv
